FILE: hdl/edca_pkg.sv
// ----------------------------------------------------------------------------
// EDCA backoff engine package
// Shared types, codes and constants of the EDCA contention engine.
// ----------------------------------------------------------------------------
package edca_pkg;

   localparam int unsigned QUEUE_LIMIT = 255;
   localparam logic [7:0]  QUEUE_CAP   = 8'((QUEUE_LIMIT > 255) ? 255 : QUEUE_LIMIT);

   localparam logic [3:0] MAX_EXP        = 4'd10;
   localparam logic [5:0] ATTEMPT_MAX    = 6'd63;
   localparam logic [3:0] CW_MIN_RESET   = 4'd4;
   localparam logic [3:0] CW_MAX_RESET   = 4'd10;
   localparam logic [5:0] RETRY_RESET    = 6'd7;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;

   typedef enum logic [2:0] {
      ACT_ARRIVAL = 3'd0,
      ACT_TICK    = 3'd1,
      ACT_BUSY    = 3'd2,
      ACT_RESUME  = 3'd3,
      ACT_RESULT  = 3'd4,
      ACT_RESTART = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      STAT_NONE      = 2'd0,
      STAT_DELIVERED = 2'd1,
      STAT_DROPPED   = 2'd2,
      STAT_REFUSED   = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CW_MIN = 2'd0,
      CSR_CW_MAX = 2'd1,
      CSR_RETRY  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [3:0] cw_min_log2;
      logic [3:0] cw_max_log2;
      logic [5:0] retry_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0] action;
      logic [9:0] random_draw;
      logic       tx_ok;
      logic       fits_before_reserved;
   } event_type;

   typedef struct packed {
      logic       transmit_request;
      logic [1:0] packet_status;
      logic [7:0] queue_count;
      logic [9:0] backoff_value;
      logic [3:0] window_log2;
      logic [5:0] attempt_count;
      logic       countdown_active;
   } result_type;

   function automatic logic [3:0] clamp_exp(input logic [3:0] e);
      return (e > MAX_EXP) ? MAX_EXP : e;
   endfunction

endpackage

FILE: hdl/edca_backoff_engine.sv
// ----------------------------------------------------------------------------
// EDCA backoff engine
// Per-station contention engine with binary exponential backoff.
// ----------------------------------------------------------------------------
// Each event enters on the req_ stream, one per transfer, and produces
// exactly one status item on the rsp_ stream. An event is held in an input
// register, then applied to the contention state as its result is written
// to an output register, once that register is empty or being read. One event
// is accepted every cycle while the receiver takes results; the state update
// is a single pass of short logic, which sets that rate.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more event; req_tready then falls until
// the result is taken. Results are never lost or repeated.
// The csr_ port writes the window limits and the retry limit; it is to be
// written only while no event is in flight. Reset clears both stages and
// returns the state and configuration to their reset values.
// ----------------------------------------------------------------------------
module edca_backoff_engine (
   input  logic                              clock,
   input  logic                              reset,
   // action[2:0], random_draw[12:3], tx_ok[13], fits_before_reserved[14]
   input  logic [edca_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // transmit_request[0], packet_status[2:1], queue_count[10:3],
   // backoff_value[20:11], window_log2[24:21], attempt_count[30:25],
   // countdown_active[31]
   output logic [edca_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [edca_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [edca_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import edca_pkg::*;

   cfg_type    cfg;
   event_type  evt_ff;
   logic       evt_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;

   assign advance    = evt_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !evt_valid_ff || advance;

   edca_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   edca_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .evt    (evt_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
      end else if (req_tready) begin
         evt_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         evt_ff.action               <= req_tdata[2:0];
         evt_ff.random_draw          <= req_tdata[12:3];
         evt_ff.tx_ok                <= req_tdata[13];
         evt_ff.fits_before_reserved <= req_tdata[14];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.countdown_active, rsp_ff.attempt_count, rsp_ff.window_log2,
                        rsp_ff.backoff_value, rsp_ff.queue_count, rsp_ff.packet_status,
                        rsp_ff.transmit_request};

endmodule

FILE: hdl/edca_csr.sv
// ----------------------------------------------------------------------------
// EDCA configuration registers
// Holds the window limits and the retry limit, written through a plain port.
// ----------------------------------------------------------------------------
module edca_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [edca_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [edca_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output edca_pkg::cfg_type               cfg
);
   import edca_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CW_MIN: cfg_in.cw_min_log2 = csr_wdata[3:0];
            CSR_CW_MAX: cfg_in.cw_max_log2 = csr_wdata[3:0];
            CSR_RETRY:  cfg_in.retry_limit = csr_wdata[5:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cw_min_log2 <= CW_MIN_RESET;
         cfg_ff.cw_max_log2 <= CW_MAX_RESET;
         cfg_ff.retry_limit <= RETRY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/edca_core.sv
// ----------------------------------------------------------------------------
// EDCA contention state
// Queue count, window exponent, backoff counter, attempts and armed flag,
// updated once for every event that passes to the result stage.
// ----------------------------------------------------------------------------
module edca_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  edca_pkg::event_type  evt,
   input  edca_pkg::cfg_type    cfg,
   output edca_pkg::result_type result
);
   import edca_pkg::*;

   logic [7:0] pend_ff, pend_in;
   logic [3:0] win_ff, win_in;
   logic [9:0] cnt_ff, cnt_in;
   logic [5:0] att_ff, att_in;
   logic       arm_ff, arm_in;

   logic [9:0] mask;
   logic [9:0] drawn;
   logic [3:0] win_up;
   logic [3:0] win_cap;
   logic       start;
   logic       attempt;
   logic       txreq;
   status_type status;

   always_comb begin
      mask    = 10'((11'd1 << clamp_exp(win_ff)) - 11'd1);
      drawn   = evt.random_draw & mask;
      win_up  = win_ff + 4'd1;
      win_cap = clamp_exp(cfg.cw_max_log2);
      pend_in = pend_ff;
      win_in  = win_ff;
      cnt_in  = cnt_ff;
      att_in  = att_ff;
      arm_in  = arm_ff;
      start   = 1'b0;
      attempt = 1'b0;
      txreq   = 1'b0;
      status  = STAT_NONE;

      unique case (action_type'(evt.action))
         ACT_ARRIVAL: begin
            if (pend_ff >= QUEUE_CAP) begin
               status = STAT_REFUSED;
            end else begin
               pend_in = pend_ff + 8'd1;
               start   = (pend_ff == 8'd0);
            end
         end
         ACT_TICK: begin
            if (arm_ff) begin
               if (pend_ff == 8'd0) begin
                  arm_in = 1'b0;
               end else if (cnt_ff == 10'd0) begin
                  start = 1'b1;
               end else begin
                  cnt_in  = cnt_ff - 10'd1;
                  attempt = (cnt_ff == 10'd1);
               end
            end
         end
         ACT_BUSY: begin
            arm_in = 1'b0;
         end
         ACT_RESUME: begin
            if (pend_ff != 8'd0) begin
               arm_in = 1'b1;
            end
         end
         ACT_RESULT: begin
            if (pend_ff != 8'd0) begin
               if (evt.tx_ok || (cfg.retry_limit != 6'd0 && att_ff >= cfg.retry_limit)) begin
                  pend_in = pend_ff - 8'd1;
                  att_in  = 6'd0;
                  win_in  = clamp_exp(cfg.cw_min_log2);
                  status  = evt.tx_ok ? STAT_DELIVERED : STAT_DROPPED;
               end else begin
                  win_in = (win_up < win_cap) ? win_up : win_cap;
               end
            end
         end
         ACT_RESTART: begin
            start = (pend_ff != 8'd0) && evt.fits_before_reserved;
         end
         default: begin
            status = STAT_NONE;
         end
      endcase

      if (start) begin
         cnt_in = drawn;
         if (drawn == 10'd0) begin
            attempt = 1'b1;
         end else begin
            arm_in = 1'b1;
         end
      end

      if (attempt) begin
         arm_in = 1'b0;
         att_in = (att_ff < ATTEMPT_MAX) ? att_ff + 6'd1 : att_ff;
         txreq  = evt.fits_before_reserved;
      end

      result.transmit_request = txreq;
      result.packet_status    = status;
      result.queue_count      = pend_in;
      result.backoff_value    = cnt_in;
      result.window_log2      = win_in;
      result.attempt_count    = att_in;
      result.countdown_active = arm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 8'd0;
         win_ff  <= CW_MIN_RESET;
         cnt_ff  <= 10'd0;
         att_ff  <= 6'd0;
         arm_ff  <= 1'b0;
      end else if (step) begin
         pend_ff <= pend_in;
         win_ff  <= win_in;
         cnt_ff  <= cnt_in;
         att_ff  <= att_in;
         arm_ff  <= arm_in;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= QUEUE_CAP)
      else $error("queue count above its limit");

   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      win_ff <= MAX_EXP)
      else $error("window exponent above maximum");

   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      step && result.packet_status == STAT_REFUSED |-> pend_ff == QUEUE_CAP)
      else $error("arrival refused while queue not full");

   a_tx_counts: assert property (@(posedge clock) disable iff (reset)
      step && result.transmit_request |=> att_ff != 6'd0 && !arm_ff)
      else $error("transmission without a counted attempt");

   a_delivered_clears: assert property (@(posedge clock) disable iff (reset)
      step && result.packet_status == STAT_DELIVERED |=> att_ff == 6'd0)
      else $error("attempts not cleared after delivery");

endmodule
